### sv/rlbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbpe_pkg
// Shared constants, types and helpers of the RGB LED bit pulse encoder.
// ----------------------------------------------------------------------------
package rlbpe_pkg;

    localparam int COLOURS         = 3;
    localparam int BITS_PER_COLOUR = 8;
    localparam int BITS_TOTAL      = COLOURS * BITS_PER_COLOUR;
    localparam int CNT_W           = $clog2(BITS_TOTAL + 1);

    localparam int BRIGHT_FULL = 255;
    localparam int DIV         = BRIGHT_FULL * BRIGHT_FULL;
    localparam int REM_W       = 18;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [5:0] SEND_ORDER_RST = 6'd33;
    localparam logic [7:0] BRIGHT_RST     = 8'd255;
    localparam logic [7:0] HIGH_PULSE_RST = 8'd60;
    localparam logic [7:0] LOW_PULSE_RST  = 8'd30;

    typedef enum logic [2:0] {
        REG_SEND_ORDER        = 3'd0,
        REG_STRIP_BRIGHTNESS  = 3'd1,
        REG_GLOBAL_BRIGHTNESS = 3'd2,
        REG_HIGH_PULSE_TICKS  = 3'd3,
        REG_LOW_PULSE_TICKS   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CODE_RED   = 2'd0,
        CODE_GREEN = 2'd1,
        CODE_BLUE  = 2'd2,
        CODE_SPARE = 2'd3
    } colour_code_t;

    typedef struct packed {
        logic [5:0] send_order;
        logic [7:0] strip_brightness;
        logic [7:0] global_brightness;
    } scale_cfg_t;

    typedef logic [COLOURS-1:0][7:0] lane_bytes_t;

    // Slots beyond those held in the register read as code zero (red)
    function automatic colour_code_t slot_code(input logic [5:0] order, input int slot);
        logic [5:0] sh;
        sh = order >> (2 * slot);
        return colour_code_t'(sh[1:0]);
    endfunction

endpackage
`default_nettype wire

### sv/rlbpe_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbpe_pix_if
// Channel carrying one LED's colour bytes.
// ----------------------------------------------------------------------------
interface rlbpe_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

### sv/rlbpe_bit_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbpe_bit_if
// Channel carrying one PWM duty value per transmitted bit.
// ----------------------------------------------------------------------------
interface rlbpe_bit_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       last_bit;

    modport source (output valid, output duty, output last_bit, input ready);
    modport sink   (input valid, input duty, input last_bit, output ready);
endinterface
`default_nettype wire

### sv/rlbpe_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbpe_scaler
// Five-stage elastic pipeline: colour selection, two brightness products,
// divide by 255*255 through a shift estimate and a remainder correction.
// ----------------------------------------------------------------------------
module rlbpe_scaler (
    input  wire                       clk,
    input  wire                       rst_n,
    input  rlbpe_pkg::scale_cfg_t     cfg,
    rlbpe_pix_if.sink                 pix,
    output logic                      out_valid,
    input  wire                       out_ready,
    output rlbpe_pkg::lane_bytes_t    out_bytes
);
    import rlbpe_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    logic [COLOURS-1:0][7:0]       sel_reg;
    logic [COLOURS-1:0][15:0]      p1_reg;
    logic [COLOURS-1:0][23:0]      p2_reg;
    logic [COLOURS-1:0][7:0]       q0_reg;
    logic [COLOURS-1:0][REM_W-1:0] rem_reg;
    logic [COLOURS-1:0][7:0]       q_reg;

    logic [COLOURS-1:0][7:0]       sel_next;
    logic [COLOURS-1:0][REM_W-1:0] rem_next;
    logic [COLOURS-1:0][7:0]       q_next;

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pix.ready = en1;
    assign out_valid = v5_reg;
    assign out_bytes = q_reg;

    always_comb
    begin
        for (int c = 0; c < COLOURS; c++)
        begin
            case (slot_code(cfg.send_order, c))
                CODE_GREEN: sel_next[c] = pix.green;
                CODE_BLUE:  sel_next[c] = pix.blue;
                default:    sel_next[c] = pix.red;
            endcase
        end
    end

    // Estimate x >> 16 undershoots x / 65025 by at most two
    always_comb
    begin
        for (int c = 0; c < COLOURS; c++)
        begin
            logic [23:0] prod;
            logic [23:0] diff;
            prod = {16'd0, p2_reg[c][23:16]} * 24'(DIV);
            diff = p2_reg[c] - prod;
            rem_next[c] = diff[REM_W-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < COLOURS; c++)
        begin
            if (rem_reg[c] >= REM_W'(2 * DIV))
                q_next[c] = q0_reg[c] + 8'd2;
            else if (rem_reg[c] >= REM_W'(DIV))
                q_next[c] = q0_reg[c] + 8'd1;
            else
                q_next[c] = q0_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pix.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < COLOURS; c++)
        begin
            if (en1)
                sel_reg[c] <= sel_next[c];
            if (en2)
                p1_reg[c] <= {8'd0, sel_reg[c]} * {8'd0, cfg.strip_brightness};
            if (en3)
                p2_reg[c] <= {8'd0, p1_reg[c]} * {16'd0, cfg.global_brightness};
            if (en4)
            begin
                q0_reg[c]  <= p2_reg[c][23:16];
                rem_reg[c] <= rem_next[c];
            end
            if (en5)
                q_reg[c] <= q_next[c];
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (rem_reg[0] < REM_W'(3 * DIV)))
        else $error("remainder out of correction range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && !out_ready |=> v5_reg && $stable(q_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire

### sv/rgb_led_bit_pulse_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_bit_pulse_encoder
// Scales one LED's colours by two brightness factors and sends 24 PWM duty
// values, one per data bit, MSB first, in the configured colour order.
// ----------------------------------------------------------------------------
// Path: an accepted LED passes the five scaler stages and is then loaded into
//   the serialiser shift register, which drives the first duty value.
// Throughput: one duty value per cycle while the bit sink is ready; the bit
//   serialiser sets that rate, the 5-stage scaler buffers up to 5 LEDs.
// Reset: rst_n is asynchronous; it empties the pipeline and serialiser and
//   loads the register reset values.
// ----------------------------------------------------------------------------
module rgb_led_bit_pulse_encoder (
    input  wire                            clk,
    input  wire                            rst_n,
    rlbpe_pix_if.sink                      pix,
    rlbpe_bit_if.source                    bits,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [rlbpe_pkg::ADDR_W-1:0]   paddr,
    input  wire  [rlbpe_pkg::DATA_W-1:0]   pwdata,
    output logic [rlbpe_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import rlbpe_pkg::*;

    logic [5:0] send_order_reg;
    logic [7:0] strip_brightness_reg;
    logic [7:0] global_brightness_reg;
    logic [7:0] high_pulse_ticks_reg;
    logic [7:0] low_pulse_ticks_reg;

    scale_cfg_t  cfg;
    logic        sc_valid;
    logic        sc_ready;
    lane_bytes_t sc_bytes;

    logic [BITS_TOTAL-1:0] shift_reg;
    logic [BITS_TOTAL-1:0] shift_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  wr;
    logic                  take;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_order_reg        <= SEND_ORDER_RST;
            strip_brightness_reg  <= BRIGHT_RST;
            global_brightness_reg <= BRIGHT_RST;
            high_pulse_ticks_reg  <= HIGH_PULSE_RST;
            low_pulse_ticks_reg   <= LOW_PULSE_RST;
        end
        else if (wr)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_SEND_ORDER:        send_order_reg        <= pwdata[5:0];
                REG_STRIP_BRIGHTNESS:  strip_brightness_reg  <= pwdata[7:0];
                REG_GLOBAL_BRIGHTNESS: global_brightness_reg <= pwdata[7:0];
                REG_HIGH_PULSE_TICKS:  high_pulse_ticks_reg  <= pwdata[7:0];
                REG_LOW_PULSE_TICKS:   low_pulse_ticks_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_SEND_ORDER:        prdata = {26'd0, send_order_reg};
            REG_STRIP_BRIGHTNESS:  prdata = {24'd0, strip_brightness_reg};
            REG_GLOBAL_BRIGHTNESS: prdata = {24'd0, global_brightness_reg};
            REG_HIGH_PULSE_TICKS:  prdata = {24'd0, high_pulse_ticks_reg};
            REG_LOW_PULSE_TICKS:   prdata = {24'd0, low_pulse_ticks_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.send_order        = send_order_reg;
    assign cfg.strip_brightness  = strip_brightness_reg;
    assign cfg.global_brightness = global_brightness_reg;

    rlbpe_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix       (pix),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_bytes (sc_bytes)
    );

    // Serialiser reloads on the final bit's transfer, so LEDs run gap-free
    assign take     = bits.valid && bits.ready;
    assign sc_ready = (cnt_reg == '0) || (take && cnt_reg == CNT_W'(1));

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            shift_next = {shift_reg[BITS_TOTAL-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
        end
        if (sc_ready && sc_valid)
        begin
            for (int c = 0; c < COLOURS; c++)
                shift_next[BITS_TOTAL-1-c*BITS_PER_COLOUR -: BITS_PER_COLOUR] = sc_bytes[c];
            cnt_next = CNT_W'(BITS_TOTAL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign bits.valid    = (cnt_reg != '0);
    assign bits.duty     = shift_reg[BITS_TOTAL-1] ? high_pulse_ticks_reg : low_pulse_ticks_reg;
    assign bits.last_bit = (cnt_reg == CNT_W'(1));

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bits.valid && !bits.ready |=> bits.valid && $stable(cnt_reg) && $stable(shift_reg))
        else $error("serialiser moved while stalled");

    a_bits_follow: assert property (@(posedge clk) disable iff (!rst_n)
        take && !bits.last_bit |=> bits.valid)
        else $error("LED bits broken off early");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && bits.last_bit && !sc_valid |=> !bits.valid)
        else $error("bit sent with no LED loaded");

endmodule
`default_nettype wire

### tb/sv/rlbpe_bit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbpe_bit_checker
// Watches the register port and both channels of the LED bit pulse encoder.
// It keeps its own copy of the registers, expands each accepted LED into its
// 24 expected duty values and checks every bit transfer against them in order.
// ----------------------------------------------------------------------------
module rlbpe_bit_checker
    import rlbpe_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    rlbpe_pix_if               pix,
    rlbpe_bit_if               bits,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire                pready,
    input  wire  [ADDR_W-1:0]  paddr,
    input  wire  [DATA_W-1:0]  pwdata,
    output int                 fail_count,
    output int                 bits_seen,
    output int                 bits_owed
);

    typedef struct packed {
        logic [7:0] duty;
        logic       last_bit;
    } bit_pulse_t;

    bit_pulse_t pulse_q[$];

    logic [5:0] order_sh;
    logic [7:0] strip_sh;
    logic [7:0] global_sh;
    logic [7:0] hi_ticks_sh;
    logic [7:0] lo_ticks_sh;

    int fail_n;
    int seen_n;

    // value * strip * global / 255^2, truncating; never above 255
    function automatic logic [7:0] dim_level(input logic [7:0] level);
        int unsigned prod;
        prod = int'(level) * int'(strip_sh) * int'(global_sh);
        return 8'(prod / DIV);
    endfunction

    task automatic expand_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [5:0]   codes;
        colour_code_t code;
        logic [7:0]   level;
        bit_pulse_t   p;
        codes = order_sh;
        for (int slot = 0; slot < COLOURS; slot++)
        begin
            // slots past the third see zeros shifted in, i.e. red
            code  = colour_code_t'(codes[1:0]);
            codes = codes >> 2;
            case (code)
                CODE_GREEN: level = g;
                CODE_BLUE:  level = b;
                default:    level = r;   // red, and the spare code falls back to red
            endcase
            level = dim_level(level);
            for (int k = BITS_PER_COLOUR - 1; k >= 0; k--)
            begin
                p.duty     = level[k] ? hi_ticks_sh : lo_ticks_sh;
                p.last_bit = (slot == COLOURS - 1) && (k == 0);
                pulse_q.push_back(p);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit_pulse_t exp_p;
        logic       bad;
        if (!rst_n)
        begin
            order_sh    = SEND_ORDER_RST;
            strip_sh    = BRIGHT_RST;
            global_sh   = BRIGHT_RST;
            hi_ticks_sh = HIGH_PULSE_RST;
            lo_ticks_sh = LOW_PULSE_RST;
            pulse_q.delete();
            fail_n      = 0;
            seen_n      = 0;
            fail_count <= 0;
            bits_seen  <= 0;
            bits_owed  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SEND_ORDER:        order_sh    = pwdata[5:0];
                    REG_STRIP_BRIGHTNESS:  strip_sh    = pwdata[7:0];
                    REG_GLOBAL_BRIGHTNESS: global_sh   = pwdata[7:0];
                    REG_HIGH_PULSE_TICKS:  hi_ticks_sh = pwdata[7:0];
                    REG_LOW_PULSE_TICKS:   lo_ticks_sh = pwdata[7:0];
                    default: ;             // unmapped: dropped
                endcase
            end

            if (pix.valid && pix.ready)
                expand_led(pix.red, pix.green, pix.blue);

            if (bits.valid && bits.ready)
            begin
                seen_n++;
                if (pulse_q.size() == 0)
                begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t checker: unexpected bit transfer duty=%0d last_bit=%0b",
                                 $realtime, bits.duty, bits.last_bit);
                end
                else
                begin
                    exp_p = pulse_q.pop_front();
                    bad   = 1'b0;
                    if (bits.duty !== exp_p.duty)
                        bad = 1'b1;
                    if (bits.last_bit !== exp_p.last_bit)
                        bad = 1'b1;
                    if (bad)
                    begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display({"%0t checker: bit %0d duty exp %0d got %0d, ",
                                      "last_bit exp %0b got %0b"},
                                     $realtime, seen_n, exp_p.duty, bits.duty,
                                     exp_p.last_bit, bits.last_bit);
                    end
                end
            end

            fail_count <= fail_n;
            bits_seen  <= seen_n;
            bits_owed  <= pulse_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LED bit pulse encoder: directed LEDs over hand-picked
// register settings, then random LEDs over random settings, with bursty
// input and a stalling bit sink. Checking is left to rlbpe_bit_checker.
// ----------------------------------------------------------------------------
module tb;
    import rlbpe_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_PHASES  = 12;
    localparam int LEDS_PER_SET = 30;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_BLOCKED
    } sink_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int bits_seen;
    int bits_owed;
    int sent_leds  = 0;
    int burst_left = 0;
    int cycle_n    = 0;

    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_left = 0;

    rlbpe_pix_if pix_ch ();
    rlbpe_bit_if bit_ch ();

    rgb_led_bit_pulse_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_ch.sink),
        .bits    (bit_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rlbpe_bit_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_ch),
        .bits       (bit_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .bits_seen  (bits_seen),
        .bits_owed  (bits_owed)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // bit sink: stall pattern switches to a random mode whenever its mode count runs out
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_left <= $urandom_range(8, 120);
        end
        else
        begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:    bit_ch.ready <= 1'b1;
            SINK_MOSTLY:  bit_ch.ready <= ($urandom_range(0, 3) != 0);
            SINK_SPARSE:  bit_ch.ready <= ($urandom_range(0, 3) == 0);
            default:      bit_ch.ready <= 1'b0;
        endcase
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'h80;
            default: return 8'($urandom());
        endcase
    endfunction

    // junk above the register width must be ignored
    function automatic logic [DATA_W-1:0] with_junk(input int width, input logic [7:0] value);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        return (junk << width) | DATA_W'(value);
    endfunction

    // back-to-back setup/access; psel stays up until set_regs drops it
    task automatic reg_write(input int unsigned index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(index << 2);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_regs(input logic [5:0] order, input logic [7:0] strip,
                            input logic [7:0] glob, input logic [7:0] hi, input logic [7:0] lo);
        reg_write(REG_SEND_ORDER,        with_junk(6, {2'b00, order}));
        reg_write(REG_STRIP_BRIGHTNESS,  with_junk(8, strip));
        reg_write(REG_GLOBAL_BRIGHTNESS, with_junk(8, glob));
        reg_write(REG_HIGH_PULSE_TICKS,  with_junk(8, hi));
        reg_write(REG_LOW_PULSE_TICKS,   with_junk(8, lo));
        reg_write(REG_LOW_PULSE_TICKS + $urandom_range(1, 3), $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        do @(posedge clk); while (!pix_ch.ready);
        sent_leds++;
    endtask

    // hold input off until every owed bit transfer has gone out
    task automatic drain_bits();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        while (bits_seen < sent_leds * BITS_TOTAL) @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full brightness leaves levels untouched
        send_led(8'h00, 8'h00, 8'h00);
        send_led(8'hFF, 8'hFF, 8'hFF);
        send_led(8'h80, 8'h01, 8'hA5);
        send_led(8'h5A, 8'hC3, 8'h3C);
        drain_bits();

        // spare code in the first slot falls back to red
        set_regs(6'h1B, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_led(8'hF0, 8'h0F, 8'hAA);
        send_led(8'h01, 8'h80, 8'h7E);
        drain_bits();

        // spare code in every slot
        set_regs(6'h3F, 8'h80, 8'hFF, 8'h00, 8'hFF);
        send_led(8'hFF, 8'h00, 8'h00);
        send_led(8'hC8, 8'h11, 8'h63);
        send_led(8'h01, 8'hFE, 8'h80);
        drain_bits();

        set_regs(6'h24, 8'h00, 8'hFF, 8'hAA, 8'h55);
        send_led(8'hFF, 8'hFF, 8'hFF);
        send_led(8'h80, 8'h40, 8'h20);
        drain_bits();

        set_regs(6'h24, 8'hFF, 8'h00, 8'h80, 8'h7F);
        send_led(8'hFF, 8'hFF, 8'hFF);
        send_led(8'h7F, 8'h01, 8'hFE);
        drain_bits();

        set_regs(6'h00, 8'h01, 8'h01, 8'h55, 8'hAA);
        send_led(8'hFF, 8'hFF, 8'hFF);
        send_led(8'h12, 8'h34, 8'h56);
        drain_bits();

        set_regs(6'h12, 8'hFE, 8'hFF, 8'h3C, 8'h1E);
        send_led(8'hFF, 8'hFF, 8'hFF);
        send_led(8'h01, 8'h02, 8'h03);
        send_led(8'hAA, 8'h55, 8'hFF);
        drain_bits();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph % 3 == 0)
                set_regs(6'($urandom()), 8'hFF, 8'hFF, pick_byte(), pick_byte());
            else
                set_regs(6'($urandom()), pick_byte(), pick_byte(), pick_byte(), pick_byte());
            for (int n = 0; n < LEDS_PER_SET; n++)
                send_led(pick_byte(), pick_byte(), pick_byte());
            drain_bits();
        end

        // let any stray transfer show up
        repeat (40) @(posedge clk);
        if (fail_count == 0 && bits_owed == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/rlbpe_pkg.sv
sv/rlbpe_pix_if.sv
sv/rlbpe_bit_if.sv
sv/rlbpe_scaler.sv
sv/rgb_led_bit_pulse_encoder.sv
tb/sv/rlbpe_bit_checker.sv
tb/sv/tb.sv
